// ===== hw/rtl/ffst_pkg.sv =====
`default_nettype none

package ffst_pkg;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_ACCESS = 2'd2,
		OP_QUERY  = 2'd3
	} ffst_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_EMPTY     = 2'd3
	} ffst_status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} ffst_state_t;

	// Register index taken from the word address of the configuration port.
	localparam logic REG_SLOT_COUNT = 1'b0;

	localparam int COUNT_W        = 7;
	localparam int INDEX_W        = 6;
	localparam int ELEM_W         = 32;
	localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 7'd64;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [INDEX_W-1:0] slot_index;
		logic [ELEM_W-1:0]  element_in;
	} ffst_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [INDEX_W-1:0] slot_out;
		logic [ELEM_W-1:0]  element_out;
		logic              is_empty;
	} ffst_result_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic clear;
	} ffst_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ffst_ctrl.sv =====
`default_nettype none

module ffst_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              cfg_clear,
	output logic                   busy,
	output ffst_pkg::ffst_cmd_t    cmd
);

	ffst_pkg::ffst_state_t state_q;
	ffst_pkg::ffst_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b0;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		cmd.clear = cfg_clear;
		unique case (state_q)
			ffst_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ffst_pkg::S_EXEC;
				end
			end
			ffst_pkg::S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
				state_d  = ffst_pkg::S_IDLE;
			end
			default: begin
				state_d = ffst_pkg::S_IDLE;
			end
		endcase
	end

	a_load_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy && cmd.exec)
		else $error("accepted item did not enter execution");

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("execution lasted more than one cycle");

	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.load)
		else $error("item loaded while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/ffst_datapath.sv =====
`default_nettype none

module ffst_datapath #(
	parameter int SLOTS        = 64,
	parameter int ELEMENT_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ffst_pkg::ffst_cmd_t          cmd,
	input  wire ffst_pkg::ffst_item_t         item,
	input  wire logic [ffst_pkg::COUNT_W-1:0] slot_count,
	output logic                              done,
	output ffst_pkg::ffst_result_t            result
);

	// A 7-bit count never reaches more than 127 slots, so storage is capped at 128 slots.
	localparam int USED      = (SLOTS < 128) ? SLOTS : 128;
	localparam int IDX_W     = (USED > 1) ? $clog2(USED) : 1;
	localparam int MEM_DEPTH = 1 << IDX_W;
	localparam int IW        = ffst_pkg::INDEX_W;
	localparam int EW        = ffst_pkg::ELEM_W;

	logic [USED-1:0]         free_q;
	logic [ELEMENT_BITS-1:0] mem [MEM_DEPTH];
	logic [ELEMENT_BITS-1:0] rd_q;

	logic [1:0]              op_q;
	logic [IW-1:0]           idx_q;
	logic [ELEMENT_BITS-1:0] elem_q;

	logic                    done_q;
	ffst_pkg::ffst_result_t  res_q;
	ffst_pkg::ffst_result_t  res_d;

	logic [7:0]              eff_count;
	logic                    in_range;
	logic [USED-1:0]         avail;
	logic                    found;
	logic [IDX_W-1:0]        first_idx;
	logic [IDX_W-1:0]        idx_addr;
	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W+IW-1:0]     idx_ext;
	logic [IDX_W+IW-1:0]     in_idx_ext;
	logic [IDX_W+IW-1:0]     first_ext;
	logic [ELEMENT_BITS+EW-1:0] elem_ext;
	logic [ELEMENT_BITS+EW-1:0] rd_ext;
	logic                    wr_en;
	logic                    set_free;
	logic                    clr_free;

	always_comb begin
		if ({1'b0, slot_count} > 8'(USED)) begin
			eff_count = 8'(USED);
		end else begin
			eff_count = {1'b0, slot_count};
		end
	end

	assign idx_ext    = {{IDX_W{1'b0}}, idx_q};
	assign in_idx_ext = {{IDX_W{1'b0}}, item.slot_index};
	assign idx_addr   = idx_ext[IDX_W-1:0];
	assign rd_addr    = in_idx_ext[IDX_W-1:0];
	assign in_range   = {2'b00, idx_q} < eff_count;
	assign elem_ext   = {{ELEMENT_BITS{1'b0}}, item.element_in};
	assign rd_ext     = {{EW{1'b0}}, rd_q};
	assign first_ext  = {{IW{1'b0}}, first_idx};

	// Only slots below the effective count take part in the search.
	always_comb begin
		for (int i = 0; i < USED; i++) begin
			avail[i] = free_q[i] && (8'(i) < eff_count);
		end
	end

	always_comb begin
		found     = 1'b0;
		first_idx = '0;
		for (int i = USED - 1; i >= 0; i--) begin
			if (avail[i]) begin
				found     = 1'b1;
				first_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		res_d.status      = ffst_pkg::ST_OK;
		res_d.slot_out    = idx_q;
		res_d.element_out = '0;
		res_d.is_empty    = 1'b0;
		wr_en             = 1'b0;
		set_free          = 1'b0;
		clr_free          = 1'b0;
		if (ffst_pkg::ffst_op_t'(op_q) == ffst_pkg::OP_ADD) begin
			if (found) begin
				res_d.slot_out = first_ext[IW-1:0];
				wr_en          = cmd.exec;
				clr_free       = cmd.exec;
			end else begin
				res_d.status   = ffst_pkg::ST_FULL;
				res_d.slot_out = '0;
			end
		end else if (!in_range) begin
			res_d.status = ffst_pkg::ST_BAD_INDEX;
		end else begin
			unique case (ffst_pkg::ffst_op_t'(op_q))
				ffst_pkg::OP_REMOVE: begin
					set_free = cmd.exec;
				end
				ffst_pkg::OP_ACCESS: begin
					if (free_q[idx_addr]) begin
						res_d.status = ffst_pkg::ST_EMPTY;
					end else begin
						res_d.element_out = rd_ext[EW-1:0];
					end
				end
				ffst_pkg::OP_QUERY: begin
					res_d.is_empty = free_q[idx_addr];
				end
				default: begin
					res_d.status = ffst_pkg::ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= item.opcode;
			idx_q  <= item.slot_index;
			elem_q <= elem_ext[ELEMENT_BITS-1:0];
			rd_q   <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[first_idx] <= elem_q;
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.clear) begin
				free_q <= '1;
			end else if (clr_free) begin
				free_q[first_idx] <= 1'b0;
			end else if (set_free) begin
				free_q[idx_addr] <= 1'b1;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_clear_frees_all: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (&free_q))
		else $error("count write left a slot occupied");

	a_add_takes_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && wr_en) |=> (!free_q[$past(first_idx)] && done_q
			&& res_q.status == ffst_pkg::ST_OK))
		else $error("successful add did not occupy its slot");

	a_full_means_none_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && ffst_pkg::ffst_op_t'(op_q) == ffst_pkg::OP_ADD && !found)
			|=> (done_q && res_q.status == ffst_pkg::ST_FULL))
		else $error("full add not reported as full");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status != ffst_pkg::ST_OK)
			|-> (res_q.element_out == '0 && !res_q.is_empty))
		else $error("error result carries data");

endmodule

`default_nettype wire

// ===== hw/rtl/first_free_slot_table.sv =====
`default_nettype none

// Slot table allocator. An item is taken when start is high and busy is low;
// busy then stays high for one cycle while the free-slot search and the table
// update run, and the result appears on result with done high for exactly one
// cycle after that. The receiver cannot stall: a result must be taken in the
// cycle done is high. A new item may be started in the same cycle that done
// shows the previous result, but not while busy is high; the element memory
// is read into a register when an item is accepted.
// Writing slot_count (register 0, byte address 0) marks every slot empty at
// once; write it only while the block is idle.
module first_free_slot_table #(
	parameter int SLOTS        = 64,
	parameter int ELEMENT_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire ffst_pkg::ffst_item_t   item,
	output logic                        done,
	output ffst_pkg::ffst_result_t      result,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [2:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [ffst_pkg::COUNT_W-1:0] slot_count_q;
	logic                         cfg_wr;
	ffst_pkg::ffst_cmd_t          cmd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == ffst_pkg::REG_SLOT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= ffst_pkg::SLOT_COUNT_RESET;
		end else if (cfg_wr) begin
			slot_count_q <= pwdata[ffst_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == ffst_pkg::REG_SLOT_COUNT) begin
			prdata = {{(32 - ffst_pkg::COUNT_W){1'b0}}, slot_count_q};
		end else begin
			prdata = '0;
		end
	end

	ffst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_clear (cfg_wr),
		.busy      (busy),
		.cmd       (cmd)
	);

	ffst_datapath #(
		.SLOTS        (SLOTS),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item       (item),
		.slot_count (slot_count_q),
		.done       (done),
		.result     (result)
	);

endmodule

`default_nettype wire

// ===== sim/tb_first_free_slot_table.sv =====
`default_nettype none

module tb_first_free_slot_table;
	import ffst_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	ffst_item_t   item = '0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic         busy;
	logic         done;
	ffst_result_t result;
	logic [31:0]  prdata;
	logic         pready;

	first_free_slot_table dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	localparam int TABLE_SLOTS = 64;

	// Shadow copy of the table and its slot count.
	bit           slot_is_free [TABLE_SLOTS];
	logic [31:0]  slot_elem [TABLE_SLOTS];
	int unsigned  slot_count_shadow;
	ffst_result_t expected_results [$];

	int idle_pct;
	int items_sent;
	int results_checked;
	int count_settings;
	int mismatch_count;
	int adds_placed;
	int full_seen;
	int bad_index_seen;
	int empty_access_seen;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("first_free_slot_table test failed");
		$finish;
	end

	function automatic ffst_result_t table_step(ffst_item_t it);
		ffst_result_t r;
		int unsigned  used;
		int           i;
		bit           placed;
		r = '0;
		placed = 1'b0;
		used = (slot_count_shadow > TABLE_SLOTS) ? TABLE_SLOTS : slot_count_shadow;
		r.slot_out = it.slot_index;
		if (it.opcode == OP_ADD) begin
			r.status = ST_FULL;
			r.slot_out = '0;
			for (i = 0; i < used && !placed; i++) begin
				if (slot_is_free[i]) begin
					slot_is_free[i] = 1'b0;
					slot_elem[i] = it.element_in;
					r.status = ST_OK;
					r.slot_out = i[INDEX_W-1:0];
					placed = 1'b1;
				end
			end
			if (placed)
				adds_placed++;
			else
				full_seen++;
		end else if (it.slot_index >= used) begin
			r.status = ST_BAD_INDEX;
			bad_index_seen++;
		end else begin
			case (it.opcode)
				OP_REMOVE: begin
					slot_is_free[it.slot_index] = 1'b1;
				end
				OP_ACCESS: begin
					if (slot_is_free[it.slot_index]) begin
						r.status = ST_EMPTY;
						empty_access_seen++;
					end else begin
						r.element_out = slot_elem[it.slot_index];
					end
				end
				default: begin
					r.is_empty = slot_is_free[it.slot_index];
				end
			endcase
		end
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %0h, got %0h", what, want, got);
	endtask

	always @(posedge clk) begin
		ffst_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				note_mismatch("result with none outstanding", '0, result);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (result.status !== want.status)
					note_mismatch("status", want.status, result.status);
				if (result.slot_out !== want.slot_out)
					note_mismatch("slot_out", want.slot_out, result.slot_out);
				if (result.element_out !== want.element_out)
					note_mismatch("element_out", want.element_out, result.element_out);
				if (result.is_empty !== want.is_empty)
					note_mismatch("is_empty", want.is_empty, result.is_empty);
			end
		end
	end

	// Returns at the edge that took the item unless an idle gap follows, in which start is low.
	task automatic send_slot_op(ffst_op_t op, int idx, logic [31:0] elem);
		ffst_item_t it;
		it.opcode = op;
		it.slot_index = idx[INDEX_W-1:0];
		it.element_in = elem;
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.push_back(table_step(it));
		items_sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	task automatic wait_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_slot_count(int unsigned value);
		wait_until_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_SLOT_COUNT, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		slot_count_shadow = value & 7'h7f;
		for (int i = 0; i < TABLE_SLOTS; i++)
			slot_is_free[i] = 1'b1;
		count_settings++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {25'd0, slot_count_shadow[6:0]})
			note_mismatch("slot_count readback", slot_count_shadow, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random_ops(int n);
		int unsigned used;
		int          idx;
		logic [31:0] elem;
		ffst_op_t    op;
		for (int k = 0; k < n; k++) begin
			used = (slot_count_shadow > TABLE_SLOTS) ? TABLE_SLOTS : slot_count_shadow;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: op = OP_ADD;
				5, 6:          op = OP_REMOVE;
				7, 8:          op = OP_ACCESS;
				default:       op = OP_QUERY;
			endcase
			// Mostly name slots below the slot count, sometimes any index.
			if (used > 0 && $urandom_range(0, 4) != 0)
				idx = $urandom_range(0, used - 1);
			else
				idx = $urandom_range(0, 63);
			case ($urandom_range(0, 7))
				0:       elem = '0;
				1:       elem = '1;
				default: elem = $urandom;
			endcase
			send_slot_op(op, idx, elem);
		end
	endtask

	task automatic test_empty_table();
		idle_pct = 35;
		send_slot_op(OP_QUERY, 0, '0);
		send_slot_op(OP_ACCESS, 0, '1);
		send_slot_op(OP_ACCESS, 63, '0);
		send_slot_op(OP_QUERY, 63, '1);
	endtask

	task automatic test_add_and_access();
		send_slot_op(OP_ADD, 63, 32'hffff_ffff);
		send_slot_op(OP_ADD, 0, 32'h0000_0000);
		send_slot_op(OP_ADD, 17, 32'h5a5a_a5a5);
		send_slot_op(OP_ACCESS, 0, '0);
		send_slot_op(OP_ACCESS, 1, '0);
		send_slot_op(OP_ACCESS, 2, '1);
		send_slot_op(OP_QUERY, 1, '0);
	endtask

	task automatic test_remove_and_reuse();
		send_slot_op(OP_REMOVE, 1, '0);
		// Removing a slot that is already empty is harmless.
		send_slot_op(OP_REMOVE, 1, '1);
		send_slot_op(OP_ACCESS, 1, '0);
		send_slot_op(OP_QUERY, 1, '0);
		send_slot_op(OP_ADD, 40, 32'h1234_5678);
		send_slot_op(OP_ACCESS, 1, '0);
	endtask

	task automatic test_single_slot();
		write_slot_count(1);
		send_slot_op(OP_ADD, 0, 32'hdead_beef);
		send_slot_op(OP_ADD, 0, 32'h8000_0001);
		send_slot_op(OP_QUERY, 0, '0);
		send_slot_op(OP_REMOVE, 1, '0);
		send_slot_op(OP_ACCESS, 63, '0);
	endtask

	task automatic test_zero_count();
		write_slot_count(0);
		send_slot_op(OP_ADD, 0, 32'h0f0f_0f0f);
		send_slot_op(OP_QUERY, 0, '0);
	endtask

	task automatic test_count_beyond_table();
		write_slot_count(127);
		send_slot_op(OP_ADD, 5, 32'hcafe_f00d);
		send_slot_op(OP_QUERY, 63, '0);
	endtask

	task automatic test_random_full_table();
		write_slot_count(64);
		idle_pct = 35;
		send_random_ops(300);
	endtask

	task automatic test_random_small_table();
		write_slot_count($urandom_range(2, 8));
		idle_pct = 52;
		send_random_ops(150);
	endtask

	task automatic test_pause_until_drained();
		idle_pct = 52;
		send_random_ops(20);
		wait_until_drained();
		send_random_ops(20);
	endtask

	task automatic test_random_back_to_back();
		write_slot_count(127);
		idle_pct = 0;
		send_random_ops(250);
		write_slot_count($urandom_range(1, 64));
		send_random_ops(160);
	endtask

	initial begin
		slot_count_shadow = SLOT_COUNT_RESET;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			slot_is_free[i] = 1'b1;
			slot_elem[i] = '0;
		end
		count_settings = 1;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_add_and_access();
		test_remove_and_reuse();
		test_single_slot();
		test_zero_count();
		test_count_beyond_table();
		test_random_full_table();
		test_random_small_table();
		test_pause_until_drained();
		test_random_back_to_back();

		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);

		$display("Sent %0d items over %0d slot count settings, checked %0d results.",
			items_sent, count_settings, results_checked);
		$display("Adds placed %0d, table full %0d, bad index %0d, empty access %0d.",
			adds_placed, full_seen, bad_index_seen, empty_access_seen);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("first_free_slot_table test passed");
		else
			$display("first_free_slot_table test failed");
		$finish;
	end

endmodule

`default_nettype wire
